// File: rtl/core/ctfp_pkg.sv
`timescale 1ns / 1ps
package ctfp_pkg;

	localparam int MAX_POINTS = 64;
	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = 7;
	localparam int SQRT_STEPS = 49;
	localparam int DIV_STEPS = 84;
	localparam int MUL_LAST = 6;
	localparam int VMUL_LAST = 2;
	localparam logic signed [63:0] OUT_MAX = 64'sd549755813887;
	localparam logic signed [63:0] OUT_MIN = -64'sd549755813888;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_START,
		S_LD_START,
		S_RD_END,
		S_LD_END,
		S_DIFF,
		S_MUL,
		S_DECIDE,
		S_VMUL,
		S_SQRT,
		S_DIV,
		S_UPDATE,
		S_DONE
	} state_t;

	function automatic logic [39:0] sat40(input logic signed [63:0] v);
		logic signed [63:0] r;
		r = v;
		if (v > OUT_MAX) r = OUT_MAX;
		if (v < OUT_MIN) r = OUT_MIN;
		return r[39:0];
	endfunction

endpackage

// File: rtl/core/cartesian_to_frenet_projection_core.sv
`timescale 1ns / 1ps
// Projects a query position onto a polyline held in a 64-entry point table.
// An item is taken when start is high and busy is low. With mode low the item
// writes one path point (x, y, arc length) into the table in that same cycle;
// busy stays low and no result follows. With mode high the item is a query:
// busy rises and the block walks the segments between the points in use, one
// at a time, through one shared 33x33 multiplier, a two-bit-per-cycle square
// root and a one-bit-per-cycle divider. A segment runs the 49 root steps when
// a vertex distance is used, and the 49 root steps and two 84-step divisions
// when the projection is used. The result appears on s_coord and l_coord for
// exactly one cycle with result_valid high, and busy falls in the next cycle.
// The receiver cannot stall the block. The user must write the point count
// register through cfg_wr_en and cfg_wr_data only while the block is idle;
// the block itself does not enforce this. Reset returns the sequencer to idle
// and sets the point count to two; table entries hold nothing until loaded.
module cartesian_to_frenet_projection_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                mode,
	input  logic [5:0]          point_index,
	input  logic signed [31:0]  x_coord,
	input  logic signed [31:0]  y_coord,
	input  logic [31:0]         arc_length,
	input  logic                cfg_wr_en,
	input  logic [6:0]          cfg_wr_data,
	output logic                result_valid,
	output logic signed [39:0]  s_coord,
	output logic signed [39:0]  l_coord
);
	import ctfp_pkg::*;

	state_t state_q, state_d;

	logic [95:0] mem [MAX_POINTS];
	logic [95:0] rdata_q;
	logic [IDX_W-1:0] rd_addr;

	logic [6:0] point_count_q;
	logic [6:0] n_q;
	logic [6:0] seg_q;
	logic [CNT_W-1:0] cnt_q;
	logic first_q;

	logic signed [31:0] qx_q, qy_q;
	logic signed [31:0] sx_q, sy_q, ex_q, ey_q;
	logic [31:0] ss_q, es_q;
	logic signed [32:0] dx_q, dy_q, x0_q, y0_q, ex0_q, ey0_q, vx_q, vy_q;

	logic signed [32:0] ma, mb;
	logic signed [65:0] prod_s1;
	logic [65:0] len2_q;
	logic signed [67:0] dot_q, cross_q;
	logic [65:0] rad_q;

	logic [97:0] sq_rad_q;
	logic [50:0] sq_rem_q;
	logic [48:0] sq_root_q;
	logic [52:0] sq_rem2, sq_trial;
	logic sq_ge;
	logic [50:0] sq_rem_next;
	logic [48:0] sq_root_next;

	logic [83:0] dv_num_q;
	logic [48:0] dv_rem_q;
	logic [63:0] dv_q_q;
	logic [48:0] len_q;
	logic [49:0] dv_r2;
	logic dv_ge;
	logic [48:0] dv_rem_next;
	logic [63:0] dv_q_next;
	logic div_sel_q, vtx_q, left_q;

	logic signed [63:0] s_c_q, best_s_q, best_l_q;
	logic [63:0] d_c_q, best_d_q;

	logic zero_len, dot_neg, past_end, seg_last;
	logic [67:0] dot_mag, cross_mag;

	assign busy = (state_q != S_IDLE);
	assign rd_addr = (state_q == S_RD_START) ? '0 : seg_q[IDX_W-1:0];
	assign zero_len = (dx_q == '0) && (dy_q == '0);
	assign dot_neg = dot_q < 0;
	assign past_end = !dot_neg && (dot_q > $signed({2'b00, len2_q}))
		&& ({1'b0, seg_q} + 8'd1 < {1'b0, n_q});
	assign seg_last = ({1'b0, seg_q} + 8'd1 >= {1'b0, n_q});
	assign dot_mag = dot_neg ? 68'(-dot_q) : 68'(dot_q);
	assign cross_mag = (cross_q < 0) ? 68'(-cross_q) : 68'(cross_q);

	always_comb begin
		ma = vx_q;
		mb = vx_q;
		if (state_q == S_MUL) begin
			case (cnt_q)
				7'd0: begin ma = dx_q; mb = dx_q; end
				7'd1: begin ma = dy_q; mb = dy_q; end
				7'd2: begin ma = x0_q; mb = dx_q; end
				7'd3: begin ma = y0_q; mb = dy_q; end
				7'd4: begin ma = x0_q; mb = dy_q; end
				default: begin ma = y0_q; mb = dx_q; end
			endcase
		end else if (cnt_q != '0) begin
			ma = vy_q;
			mb = vy_q;
		end
	end

	always_comb begin
		sq_rem2 = {sq_rem_q, sq_rad_q[97:96]};
		sq_trial = {2'b00, sq_root_q, 2'b01};
		sq_ge = sq_rem2 >= sq_trial;
		sq_rem_next = sq_ge ? 51'(sq_rem2 - sq_trial) : sq_rem2[50:0];
		sq_root_next = {sq_root_q[47:0], sq_ge};
		dv_r2 = {dv_rem_q, dv_num_q[83]};
		dv_ge = dv_r2 >= {1'b0, len_q};
		dv_rem_next = dv_ge ? 49'(dv_r2 - {1'b0, len_q}) : dv_r2[48:0];
		dv_q_next = {dv_q_q[62:0], dv_ge};
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (start && mode) state_d = S_RD_START;
			S_RD_START: state_d = S_LD_START;
			S_LD_START: state_d = S_RD_END;
			S_RD_END: state_d = S_LD_END;
			S_LD_END: state_d = S_DIFF;
			S_DIFF: state_d = S_MUL;
			S_MUL: if (cnt_q == CNT_W'(MUL_LAST)) state_d = S_DECIDE;
			S_DECIDE: begin
				if (zero_len || (dot_neg && seg_q > 7'd1) || past_end) state_d = S_VMUL;
				else state_d = S_SQRT;
			end
			S_VMUL: if (cnt_q == CNT_W'(VMUL_LAST)) state_d = S_SQRT;
			S_SQRT: begin
				if (cnt_q == CNT_W'(SQRT_STEPS - 1)) state_d = vtx_q ? S_UPDATE : S_DIV;
			end
			S_DIV: if (cnt_q == CNT_W'(DIV_STEPS - 1) && div_sel_q) state_d = S_UPDATE;
			S_UPDATE: state_d = seg_last ? S_DONE : S_RD_END;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		result_valid = (state_q == S_DONE);
		s_coord = $signed(sat40(best_s_q));
		l_coord = $signed(sat40(best_l_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			point_count_q <= 7'd2;
			cnt_q <= '0;
			seg_q <= 7'd1;
			first_q <= 1'b1;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) point_count_q <= cfg_wr_data;
			if (state_d != state_q) cnt_q <= '0;
			else if (state_q == S_DIV && cnt_q == CNT_W'(DIV_STEPS - 1)) cnt_q <= '0;
			else cnt_q <= cnt_q + 1'b1;
			if (state_q == S_IDLE) begin
				seg_q <= 7'd1;
				first_q <= 1'b1;
			end else if (state_q == S_UPDATE) begin
				seg_q <= seg_q + 1'b1;
				first_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy && start && !mode) mem[point_index] <= {x_coord, y_coord, arc_length};
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		prod_s1 <= ma * mb;
		unique case (state_q)
			S_IDLE: begin
				qx_q <= x_coord;
				qy_q <= y_coord;
				if (point_count_q < 7'd2) n_q <= 7'd2;
				else if (point_count_q > 7'(MAX_POINTS)) n_q <= 7'(MAX_POINTS);
				else n_q <= point_count_q;
			end
			S_LD_START: begin
				sx_q <= rdata_q[95:64];
				sy_q <= rdata_q[63:32];
				ss_q <= rdata_q[31:0];
			end
			S_LD_END: begin
				ex_q <= rdata_q[95:64];
				ey_q <= rdata_q[63:32];
				es_q <= rdata_q[31:0];
			end
			S_DIFF: begin
				dx_q <= 33'(ex_q) - 33'(sx_q);
				dy_q <= 33'(ey_q) - 33'(sy_q);
				x0_q <= 33'(qx_q) - 33'(sx_q);
				y0_q <= 33'(qy_q) - 33'(sy_q);
				ex0_q <= 33'(qx_q) - 33'(ex_q);
				ey0_q <= 33'(qy_q) - 33'(ey_q);
			end
			S_MUL: begin
				case (cnt_q)
					7'd1: len2_q <= prod_s1[65:0];
					7'd2: len2_q <= len2_q + prod_s1[65:0];
					7'd3: dot_q <= 68'(prod_s1);
					7'd4: dot_q <= dot_q + 68'(prod_s1);
					7'd5: cross_q <= 68'(prod_s1);
					7'd6: cross_q <= cross_q - 68'(prod_s1);
					default: ;
				endcase
			end
			S_DECIDE: begin
				left_q <= zero_len ? 1'b1 : (cross_q < 0);
				vtx_q <= 1'b1;
				vx_q <= x0_q;
				vy_q <= y0_q;
				s_c_q <= 64'(ss_q);
				if (!zero_len && !(dot_neg && seg_q > 7'd1)) begin
					if (past_end) begin
						vx_q <= ex0_q;
						vy_q <= ey0_q;
						s_c_q <= 64'(es_q);
					end else begin
						vtx_q <= 1'b0;
						sq_rad_q <= {len2_q, 32'd0};
						sq_rem_q <= '0;
						sq_root_q <= '0;
					end
				end
			end
			S_VMUL: begin
				if (cnt_q == 7'd1) rad_q <= prod_s1[65:0];
				if (cnt_q == CNT_W'(VMUL_LAST)) begin
					sq_rad_q <= {32'd0, rad_q + prod_s1[65:0]};
					sq_rem_q <= '0;
					sq_root_q <= '0;
				end
			end
			S_SQRT: begin
				sq_rad_q <= {sq_rad_q[95:0], 2'b00};
				sq_rem_q <= sq_rem_next;
				sq_root_q <= sq_root_next;
				if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
					d_c_q <= 64'(sq_root_next);
					len_q <= sq_root_next;
					dv_num_q <= {dot_mag, 16'd0};
					dv_rem_q <= '0;
					dv_q_q <= '0;
					div_sel_q <= 1'b0;
				end
			end
			S_DIV: begin
				dv_num_q <= {dv_num_q[82:0], 1'b0};
				dv_rem_q <= dv_rem_next;
				dv_q_q <= dv_q_next;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					if (!div_sel_q) begin
						s_c_q <= dot_neg ? 64'(ss_q) - $signed(dv_q_next)
							: 64'(ss_q) + $signed(dv_q_next);
						dv_num_q <= {cross_mag, 16'd0};
						dv_rem_q <= '0;
						dv_q_q <= '0;
						div_sel_q <= 1'b1;
					end else begin
						d_c_q <= dv_q_next;
					end
				end
			end
			S_UPDATE: begin
				if (first_q || d_c_q < best_d_q) begin
					best_d_q <= d_c_q;
					best_s_q <= s_c_q;
					best_l_q <= left_q ? $signed(d_c_q) : -$signed(d_c_q);
				end
				sx_q <= ex_q;
				sy_q <= ey_q;
				ss_q <= es_q;
			end
			default: ;
		endcase
	end

	ap_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");
	ap_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode) |=> busy)
		else $error("query did not raise busy");
	ap_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !mode) |=> !busy)
		else $error("load item raised busy");
	ap_seg_range: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && state_q != S_DONE) |-> (seg_q >= 7'd1 && seg_q < n_q))
		else $error("segment index out of range");
	ap_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == S_UPDATE))
		else $error("result without a final segment");

endmodule

// File: sim/cartesian_to_frenet_projection_core_test.sv
`timescale 1ns / 1ps
module cartesian_to_frenet_projection_core_test;
	import ctfp_pkg::*;

	class proj_scoreboard;
		logic signed [39:0] want_s[$];
		logic signed [39:0] want_l[$];
		int errors = 0;
		int checked = 0;

		function void note_query(logic signed [39:0] s, logic signed [39:0] l);
			want_s.push_back(s);
			want_l.push_back(l);
		endfunction

		function void check_result(logic signed [39:0] s, logic signed [39:0] l);
			logic signed [39:0] es;
			logic signed [39:0] el;
			if (want_s.size() == 0) begin
				$error("result with no query pending: s_coord=%0d l_coord=%0d", s, l);
				errors++;
				return;
			end
			es = want_s.pop_front();
			el = want_l.pop_front();
			checked++;
			if (s !== es) begin
				$error("s_coord mismatch: expected %0d actual %0d", es, s);
				errors++;
			end
			if (l !== el) begin
				$error("l_coord mismatch: expected %0d actual %0d", el, l);
				errors++;
			end
		endfunction

		function int pending();
			return want_s.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic mode = 1'b0;
	logic [5:0] point_index = '0;
	logic signed [31:0] x_coord = '0;
	logic signed [31:0] y_coord = '0;
	logic [31:0] arc_length = '0;
	logic cfg_wr_en = 1'b0;
	logic [6:0] cfg_wr_data = '0;
	logic result_valid;
	logic signed [39:0] s_coord;
	logic signed [39:0] l_coord;

	proj_scoreboard sb = new();

	logic signed [31:0] path_x[MAX_POINTS];
	logic signed [31:0] path_y[MAX_POINTS];
	logic [31:0] path_s[MAX_POINTS];
	logic [6:0] point_count_reg = 7'd2;
	int items_sent = 0;
	int loads_sent = 0;
	int queries_sent = 0;
	int counts_used = 0;
	bit idling_on = 1'b1;

	cartesian_to_frenet_projection_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.point_index(point_index),
		.x_coord(x_coord),
		.y_coord(y_coord),
		.arc_length(arc_length),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.result_valid(result_valid),
		.s_coord(s_coord),
		.l_coord(l_coord)
	);

	always #1 clk = ~clk;

	function automatic int points_in_use(logic [6:0] v);
		if (v < 2) return 2;
		if (v > MAX_POINTS) return MAX_POINTS;
		return v;
	endfunction

	function automatic logic [63:0] root_floor(logic [127:0] v);
		logic [63:0] r;
		logic [63:0] t;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if ({64'd0, t} * {64'd0, t} <= v) r = t;
		end
		return r;
	endfunction

	function automatic logic [127:0] magnitude(logic signed [127:0] a);
		return a < 0 ? -a : a;
	endfunction

	function automatic logic [39:0] clamp40(logic signed [63:0] v);
		if (v > OUT_MAX) return OUT_MAX[39:0];
		if (v < OUT_MIN) return OUT_MIN[39:0];
		return v[39:0];
	endfunction

	task automatic frenet_of(input logic signed [31:0] px, input logic signed [31:0] py,
			output logic signed [39:0] s_out, output logic signed [39:0] l_out);
		logic signed [127:0] qx, qy, sx, sy, ex, ey, dx, dy, x0, y0;
		logic signed [127:0] len2, dot, cr;
		logic [127:0] q;
		logic [63:0] len, d, best_d, proj;
		logic signed [63:0] s, best_s, best_l;
		bit have, left, dneg;
		int n;
		n = points_in_use(point_count_reg);
		qx = px;
		qy = py;
		have = 0;
		best_d = 0;
		best_s = 0;
		best_l = 0;
		for (int i = 1; i < n; i++) begin
			sx = path_x[i - 1];
			sy = path_y[i - 1];
			ex = path_x[i];
			ey = path_y[i];
			dx = ex - sx;
			dy = ey - sy;
			x0 = qx - sx;
			y0 = qy - sy;
			left = 1;
			if (dx == 0 && dy == 0) begin
				s = {32'd0, path_s[i - 1]};
				d = root_floor(x0 * x0 + y0 * y0);
			end else begin
				len2 = dx * dx + dy * dy;
				dot = x0 * dx + y0 * dy;
				cr = x0 * dy - y0 * dx;
				len = root_floor(len2 <<< 32);
				dneg = dot < 0;
				left = cr < 0;
				if (dneg && i > 1) begin
					s = {32'd0, path_s[i - 1]};
					d = root_floor(x0 * x0 + y0 * y0);
				end else if (!dneg && dot > len2 && i + 1 < n) begin
					s = {32'd0, path_s[i]};
					d = root_floor((qx - ex) * (qx - ex) + (qy - ey) * (qy - ey));
				end else begin
					q = (magnitude(dot) << 16) / {64'd0, len};
					proj = q[63:0];
					s = $signed({32'd0, path_s[i - 1]}) + (dneg ? -$signed(proj) : $signed(proj));
					q = (magnitude(cr) << 16) / {64'd0, len};
					d = q[63:0];
				end
			end
			if (!have || d < best_d) begin
				have = 1;
				best_d = d;
				best_s = s;
				best_l = left ? $signed(d) : -$signed(d);
			end
		end
		s_out = clamp40(best_s);
		l_out = clamp40(best_l);
	endtask

	function automatic logic [31:0] pick32();
		int r;
		r = $urandom_range(0, 7);
		case (r)
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2, 3, 4: return $urandom_range(0, 32'h00FFFFFF) - 32'h00800000;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(input logic m, input logic [5:0] idx, input logic [31:0] x,
			input logic [31:0] y, input logic [31:0] a);
		int gap;
		logic signed [39:0] es, el;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start = 1'b1;
		mode = m;
		point_index = idx;
		x_coord = x;
		y_coord = y;
		arc_length = a;
		while (busy) @(negedge clk);
		if (m == 1'b0) begin
			path_x[idx] = x;
			path_y[idx] = y;
			path_s[idx] = a;
			loads_sent++;
		end else begin
			frenet_of(x, y, es, el);
			sb.note_query(es, el);
			queries_sent++;
		end
		items_sent++;
		@(posedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (sb.pending() > 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_point_count(input logic [6:0] v);
		drain();
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		point_count_reg = v;
		counts_used++;
	endtask

	always @(posedge clk) begin
		if (result_valid) sb.check_result(s_coord, l_coord);
	end

	initial begin
		#20000000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		logic [6:0] cv;
		int n;
		int nq;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		write_point_count(7'd3);
		send_item(0, 0, 0, 0, 0);
		send_item(0, 1, 0, 0, 32'd1000);
		send_item(0, 2, 32'd10 << 16, 0, 32'd10 << 16);
		send_item(1, 0, 32'd3 << 16, 32'd2 << 16, 0);
		send_item(1, 0, 32'd3 << 16, -(32'd2 << 16), 0);
		send_item(1, 0, -(32'd5 << 16), 1, 0);
		send_item(1, 0, 32'd20 << 16, 32'd1 << 16, 0);
		send_item(0, 1, 32'd5 << 16, 32'd5 << 16, 32'd7 << 16);
		send_item(1, 0, 32'd5 << 16, 0, 0);
		send_item(1, 0, 32'd6 << 16, 32'd6 << 16, 0);
		send_item(0, 2, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
		send_item(1, 0, 32'h80000000, 32'h7FFFFFFF, 0);
		send_item(1, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0);
		send_item(0, 0, 32'h80000000, 32'h80000000, 32'hFFFFFFFF);
		send_item(1, 6'd63, 0, 0, 32'hFFFFFFFF);
		write_point_count(7'd2);
		send_item(1, 0, 32'd5 << 16, 32'd5 << 16, 0);
		write_point_count(7'd0);
		send_item(1, 0, 32'h80000000, 32'h80000000, 0);

		while (items_sent < 900) begin
			if (items_sent > 780) idling_on = 0;
			case ($urandom_range(0, 9))
				0: cv = 7'($urandom_range(0, 1));
				1: cv = 7'($urandom_range(7, 127));
				default: cv = 7'($urandom_range(2, 6));
			endcase
			write_point_count(cv);
			n = points_in_use(cv);
			for (int k = 0; k < n; k++)
				send_item(0, 6'(k), pick32(), pick32(), pick32());
			nq = n > 16 ? 3 : $urandom_range(8, 25);
			for (int k = 0; k < nq; k++) begin
				if ($urandom_range(0, 4) == 0)
					send_item(0, 6'($urandom_range(0, 63)), pick32(), pick32(), pick32());
				send_item(1, 6'($urandom), pick32(), pick32(), $urandom);
			end
		end

		drain();
		$display("Covered %0d loads and %0d queries (%0d results checked) over %0d point counts.",
			loads_sent, queries_sent, sb.checked, counts_used);
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/core/ctfp_pkg.sv
rtl/core/cartesian_to_frenet_projection_core.sv
sim/cartesian_to_frenet_projection_core_test.sv
